FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fpct_pkg.sv
// Types and constants shared by the farthest point and centroid tracker.
package fpct_pkg;

   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 20;
   localparam int SQ_W        = 32;
   localparam int DIST_W      = 34;
   localparam int SUM_W       = 29;
   localparam int COUNT_OUT_W = 13;
   localparam int LANES       = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 168;

   localparam logic [CSR_IDX_W-1:0] REG_TIP_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIP_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIP_Z = 2'd2;

   // One classified point on its way from the front to the back.
   typedef struct packed {
      logic                          first;
      logic                          last;
      logic [INDEX_W-1:0]            index;
      logic [LANES-1:0][COORD_W-1:0] pos;
      logic [DIST_W-1:0]             dist_sq;
   } item_type;

   // One result as it leaves the back.
   typedef struct packed {
      logic [LANES-1:0][COORD_W-1:0] far_pos;
      logic [INDEX_W-1:0]            far_index;
      logic [DIST_W-1:0]             far_dist_sq;
      logic                          found;
      logic [LANES-1:0][COORD_W-1:0] mean;
      logic                          mean_valid;
      logic [COUNT_OUT_W-1:0]        point_count;
   } result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: src/fpct_fifo.sv
// Two-entry queue between the front and the back.
module fpct_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: src/fpct_front.sv
// Front end: tip registers, point intake and squared distance to the tip.
module fpct_front
   import fpct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output item_type              out_item
);

   logic [LANES-1:0][COORD_W-1:0] tip_ff, tip_in;
   logic                          s1_valid_ff, s1_valid_in;
   item_type                      s1_item_ff, s1_item_in;
   logic [LANES-1:0][SQ_W-1:0]    s1_sq_ff, s1_sq_in;
   logic                          req_take;
   logic signed [COORD_W:0]       diff [LANES];
   logic [COORD_W:0]              mag  [LANES];

   assign csr_ready  = 1'b1;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      tip_in = tip_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIP_X: tip_in[0] = csr_data;
            REG_TIP_Y: tip_in[1] = csr_data;
            REG_TIP_Z: tip_in[2] = csr_data;
            default:   tip_in    = tip_ff;
         endcase
      end
   end

   always_comb begin
      s1_item_in.pos     = req_tdata[LANES*COORD_W-1:0];
      s1_item_in.index   = req_tdata[LANES*COORD_W +: INDEX_W];
      s1_item_in.first   = req_tuser;
      s1_item_in.last    = req_tlast;
      s1_item_in.dist_sq = '0;
      for (int i = 0; i < LANES; i++) begin
         diff[i] = $signed({s1_item_in.pos[i][COORD_W-1], s1_item_in.pos[i]})
                 - $signed({tip_ff[i][COORD_W-1], tip_ff[i]});
         mag[i]  = diff[i][COORD_W] ? (COORD_W+1)'(-diff[i]) : (COORD_W+1)'(diff[i]);
         s1_sq_in[i] = mag[i][COORD_W-1:0] * mag[i][COORD_W-1:0];
      end
   end

   assign s1_valid_in = req_take ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tip_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         tip_ff      <= tip_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
         s1_sq_ff   <= s1_sq_in;
      end
   end

   // Three squares of at most 65535^2 each never reach the 34-bit limit.
   always_comb begin
      out_item         = s1_item_ff;
      out_item.dist_sq = DIST_W'(s1_sq_ff[0]) + DIST_W'(s1_sq_ff[1])
                       + DIST_W'(s1_sq_ff[2]);
   end

   assign out_valid = s1_valid_ff;

endmodule

FILE: src/fpct_div.sv
// Restoring divider, one quotient bit per cycle, for one coordinate mean.
module fpct_div
   import fpct_pkg::*;
#(
   parameter int DEN_W = 13
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_status_type     status,
   output logic [SUM_W-1:0]   quo
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    shifted;
   logic              ge;

   assign shifted = {rem_ff[DEN_W-1:0], num_ff[SUM_W-1]};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_comb begin
      step_in = step_ff;
      done_in = done_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         step_in = STEP_W'(SUM_W);
         done_in = 1'b0;
         rem_in  = '0;
         num_in  = num;
         den_in  = den;
      end else if (step_ff != '0) begin
         rem_in  = ge ? (shifted - {1'b0, den_ff}) : shifted;
         num_in  = {num_ff[SUM_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign status.busy = (step_ff != '0);
   assign status.done = done_ff;
   assign quo         = num_ff;

endmodule

FILE: src/fpct_back.sv
// Back end: farthest point tracking, saturating sums, count and mean.
module fpct_back
   import fpct_pkg::*;
#(
   parameter int MAX_POINTS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [DIST_W-1:0]             best_dist_ff, best_dist_in;
   logic [LANES-1:0][COORD_W-1:0] best_pos_ff, best_pos_in;
   logic [INDEX_W-1:0]            best_index_ff, best_index_in;
   logic                          best_found_ff, best_found_in;
   logic [SUM_W-1:0]              sum_ff [LANES];
   logic [SUM_W-1:0]              sum_in [LANES];
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          out_valid_ff, out_valid_in;
   result_type                    out_data_ff, out_data_in;

   logic                          out_free, pop, take, better;
   logic [DIST_W-1:0]             base_dist;
   logic [LANES-1:0][COORD_W-1:0] base_pos;
   logic [INDEX_W-1:0]            base_index;
   logic                          base_found;
   logic [SUM_W-1:0]              base_sum [LANES];
   logic [CNT_W-1:0]              base_count;
   logic                          div_start;
   logic [SUM_W-1:0]              div_num  [LANES];
   logic [SUM_W-1:0]              div_quo  [LANES];
   div_status_type                div_stat [LANES];
   logic                          div_done;
   logic [LANES-1:0][COORD_W-1:0] mean_val;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [COORD_W-1:0] p);
      logic [SUM_W:0] t;
      t = {s[SUM_W-1], s} + {{(SUM_W+1-COORD_W){p[COORD_W-1]}}, p};
      if (t[SUM_W] != t[SUM_W-1]) begin
         sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = t[SUM_W-1:0];
      end
   endfunction

   function automatic logic [SUM_W-1:0] abs_sum(input logic [SUM_W-1:0] s);
      abs_sum = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
   endfunction

   // Give back the signed mean from the quotient magnitude, clamped to 16 bits.
   function automatic logic [COORD_W-1:0] mean_of(input logic neg,
                                                  input logic [SUM_W-1:0] q,
                                                  input logic empty);
      if (empty) begin
         mean_of = '0;
      end else if (!neg) begin
         mean_of = (q > SUM_W'(32767)) ? 16'h7FFF : q[COORD_W-1:0];
      end else begin
         mean_of = (q > SUM_W'(32768)) ? 16'h8000 : (~q[COORD_W-1:0] + 16'd1);
      end
   endfunction

   assign out_free = !out_valid_ff || out_ready;
   assign pop      = (state_ff == ST_RUN) && in_valid && out_free;
   assign in_ready = (state_ff == ST_RUN) && out_free;

   // A first-flagged item starts from a cleared cloud.
   always_comb begin
      base_dist  = in_item.first ? '0 : best_dist_ff;
      base_pos   = in_item.first ? '0 : best_pos_ff;
      base_index = in_item.first ? '0 : best_index_ff;
      base_found = in_item.first ? 1'b0 : best_found_ff;
      base_count = in_item.first ? '0 : count_ff;
      for (int i = 0; i < LANES; i++) begin
         base_sum[i] = in_item.first ? '0 : sum_ff[i];
      end
      take   = (base_count < CNT_W'(MAX_POINTS));
      better = take && (in_item.dist_sq > base_dist);
   end

   assign div_start = (state_ff == ST_LOAD);
   assign div_done  = div_stat[0].done && div_stat[1].done && div_stat[2].done;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         div_num[i]  = abs_sum(sum_ff[i]) + SUM_W'(count_ff >> 1);
         mean_val[i] = mean_of(sum_ff[i][SUM_W-1], div_quo[i], count_ff == '0);
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_div
      fpct_div #(
         .DEN_W (CNT_W)
      ) u_div (
         .clock  (clock),
         .reset  (reset),
         .start  (div_start),
         .num    (div_num[g]),
         .den    (count_ff),
         .status (div_stat[g]),
         .quo    (div_quo[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      best_dist_in  = best_dist_ff;
      best_pos_in   = best_pos_ff;
      best_index_in = best_index_ff;
      best_found_in = best_found_ff;
      count_in      = count_ff;
      for (int i = 0; i < LANES; i++) begin
         sum_in[i] = sum_ff[i];
      end
      out_valid_in = out_ready ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;

      case (state_ff)
         ST_RUN: begin
            if (pop) begin
               best_dist_in  = better ? in_item.dist_sq : base_dist;
               best_pos_in   = better ? in_item.pos     : base_pos;
               best_index_in = better ? in_item.index   : base_index;
               best_found_in = better ? 1'b1            : base_found;
               count_in      = take ? base_count + CNT_W'(1) : base_count;
               for (int i = 0; i < LANES; i++) begin
                  sum_in[i] = take ? sat_add(base_sum[i], in_item.pos[i]) : base_sum[i];
               end
               if (in_item.last) begin
                  state_in = ST_LOAD;
               end else begin
                  out_valid_in            = 1'b1;
                  out_data_in.far_pos     = best_pos_in;
                  out_data_in.far_index   = best_index_in;
                  out_data_in.far_dist_sq = best_dist_in;
                  out_data_in.found       = best_found_in;
                  out_data_in.mean        = '0;
                  out_data_in.mean_valid  = 1'b0;
                  out_data_in.point_count = COUNT_OUT_W'(count_in);
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done && out_free) begin
               state_in                = ST_RUN;
               out_valid_in            = 1'b1;
               out_data_in.far_pos     = best_pos_ff;
               out_data_in.far_index   = best_index_ff;
               out_data_in.far_dist_sq = best_dist_ff;
               out_data_in.found       = best_found_ff;
               out_data_in.mean        = mean_val;
               out_data_in.mean_valid  = 1'b1;
               out_data_in.point_count = COUNT_OUT_W'(count_ff);
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         best_dist_ff  <= '0;
         best_pos_ff   <= '0;
         best_index_ff <= '0;
         best_found_ff <= 1'b0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         best_dist_ff  <= best_dist_in;
         best_pos_ff   <= best_pos_in;
         best_index_ff <= best_index_in;
         best_found_ff <= best_found_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: src/farthest_point_and_centroid_tracker_unit.sv
// Farthest point and centroid tracker: top level.
//
// Points enter on the req_ stream, one per transfer; every point gives exactly one
// result transfer on the rsp_ stream, in order. req_tuser set clears the cloud
// before that point; req_tlast set asks for the cloud mean, returned with rsp_tlast.
// The user must write the tip point through the csr_ port only while no point is
// in flight; the block itself does not enforce this. An ordinary point passes the
// front stage register, the two-entry queue and the result register; a last-flagged
// point also waits for the 29-step restoring divider of each mean coordinate (three
// run side by side). One point per cycle between mean requests while rsp_tready is
// high; a mean request holds the back end while the front keeps filling its queue.
// When the receiver holds rsp_tready low the result register holds its data,
// the two-entry queue fills, and then req_tready drops.
// Reset clears the tip, the farthest point, sums and count; no clearing pass.
module farthest_point_and_centroid_tracker_unit
   import fpct_pkg::*;
#(
   parameter int MAX_POINTS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pos_x, pos_y, pos_z, point_index, zero pad
   input  logic                  req_tuser,   // first
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // far_x, far_y, far_z, far_index, far_dist_sq, mean_x, mean_y, mean_z,
   // point_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // found
   output logic                  rsp_tlast,   // mean_valid
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_data
);

   logic       fr_valid, fr_ready;
   item_type   fr_item;
   logic       q_valid, q_ready;
   item_type   q_item;
   result_type result;

   fpct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .out_valid  (fr_valid),
      .out_ready  (fr_ready),
      .out_item   (fr_item)
   );

   fpct_fifo #(
      .WIDTH ($bits(item_type))
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_item)
   );

   fpct_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {5'd0,
                       result.point_count,
                       result.mean[2], result.mean[1], result.mean[0],
                       result.far_dist_sq,
                       result.far_index,
                       result.far_pos[2], result.far_pos[1], result.far_pos[0]};
   assign rsp_tuser = result.found;
   assign rsp_tlast = result.mean_valid;

endmodule

FILE: src/fpct_checker.sv
// Port-level checks for the farthest point and centroid tracker.
`include "assert_macros.svh"

module fpct_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `ASSERT_CLK(a_rsp_holds, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `ASSERT_CLK(a_mean_zero, clock, reset,
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[149:102] == 48'd0, "mean set without mean_valid")

   `ASSERT_CLK(a_dist_needs_found, clock, reset,
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[101:68] == 34'd0, "distance set without found")

   `ASSERT_CLK(a_pad_zero, clock, reset,
      rsp_tvalid |-> rsp_tdata[167:163] == 5'd0, "result padding not zero")

endmodule

bind farthest_point_and_centroid_tracker_unit fpct_checker u_fpct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/sv/tb.sv
// Testbench for the farthest point and centroid tracker: directed and random point clouds.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpct_pkg::*;

   localparam int     MAX_POINTS    = 4096;
   localparam int     QUIET_LIMIT   = 1000;
   localparam int     SETTLE_CYCLES = 40;
   localparam longint DIST_MAX      = (longint'(1) << DIST_W) - 1;
   localparam longint SUM_MAX       = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_MIN       = -(longint'(1) << (SUM_W - 1));

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INDEX_W-1:0]        idx;
      logic                      first;
      logic                      last;
   } point_type;

   typedef struct {
      logic signed [COORD_W-1:0] far_x;
      logic signed [COORD_W-1:0] far_y;
      logic signed [COORD_W-1:0] far_z;
      logic [INDEX_W-1:0]        far_index;
      logic [DIST_W-1:0]         far_dist_sq;
      logic                      found;
      logic signed [COORD_W-1:0] mean_x;
      logic signed [COORD_W-1:0] mean_y;
      logic signed [COORD_W-1:0] mean_z;
      logic                      mean_valid;
      logic [COUNT_OUT_W-1:0]    point_count;
   } report_type;

   // Tracks the farthest point and the cloud sums, and holds the reports still owed.
   class cloud_tracker_scoreboard;
      logic signed [COORD_W-1:0] tip [3];
      longint                    best_dist;
      logic signed [COORD_W-1:0] best_pos [3];
      logic [INDEX_W-1:0]        best_idx;
      logic                      best_found;
      longint                    sums [3];
      int                        count;
      report_type                pending_reports [$];
      int                        errors;
      int                        reports_seen;
      int                        means_seen;

      function new();
         foreach (tip[a]) tip[a] = '0;
         clear_cloud();
      endfunction

      function void clear_cloud();
         best_dist  = 0;
         best_idx   = '0;
         best_found = 1'b0;
         count      = 0;
         foreach (best_pos[a]) begin
            best_pos[a] = '0;
            sums[a]     = 0;
         end
      endfunction

      function void set_tip(logic [CSR_IDX_W-1:0] reg_idx, logic [COORD_W-1:0] value);
         case (reg_idx)
            REG_TIP_X: tip[0] = value;
            REG_TIP_Y: tip[1] = value;
            REG_TIP_Z: tip[2] = value;
            default: ;
         endcase
      endfunction

      // Nearest integer, ties away from zero, clamped to the coordinate range.
      function logic signed [COORD_W-1:0] cloud_mean(longint sum);
         longint mag;
         longint q;
         if (count == 0) return '0;
         mag = (sum < 0) ? -sum : sum;
         q = (mag + longint'(count / 2)) / longint'(count);
         if (sum < 0) q = -q;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[COORD_W-1:0];
      endfunction

      function void note_point(point_type p);
         logic signed [COORD_W-1:0] pos [3];
         longint     dist_sq;
         longint     diff;
         report_type r;
         pos[0] = p.x;
         pos[1] = p.y;
         pos[2] = p.z;
         if (p.first) clear_cloud();
         // a full cloud ignores further points but still answers a mean request
         if (count < MAX_POINTS) begin
            dist_sq = 0;
            foreach (pos[a]) begin
               diff = longint'(tip[a]) - longint'(pos[a]);
               dist_sq += diff * diff;
            end
            if (dist_sq > DIST_MAX) dist_sq = DIST_MAX;
            if (dist_sq > best_dist) begin
               best_dist  = dist_sq;
               best_pos   = pos;
               best_idx   = p.idx;
               best_found = 1'b1;
            end
            foreach (pos[a]) begin
               sums[a] += longint'(pos[a]);
               if (sums[a] > SUM_MAX) sums[a] = SUM_MAX;
               if (sums[a] < SUM_MIN) sums[a] = SUM_MIN;
            end
            count++;
         end
         r.far_x       = best_pos[0];
         r.far_y       = best_pos[1];
         r.far_z       = best_pos[2];
         r.far_index   = best_idx;
         r.far_dist_sq = best_dist[DIST_W-1:0];
         r.found       = best_found;
         r.mean_valid  = p.last;
         r.mean_x      = p.last ? cloud_mean(sums[0]) : '0;
         r.mean_y      = p.last ? cloud_mean(sums[1]) : '0;
         r.mean_z      = p.last ? cloud_mean(sums[2]) : '0;
         r.point_count = COUNT_OUT_W'(count);
         pending_reports.push_back(r);
      endfunction

      function void flag_error(string msg);
         errors++;
         if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
      endfunction

      function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
         if (want !== got)
            flag_error($sformatf("report %0d, %s: expected %0d, got %0d",
                                 reports_seen, name, want, got));
      endfunction

      function void check_report(report_type got);
         report_type want;
         reports_seen++;
         if (got.mean_valid === 1'b1) means_seen++;
         if (pending_reports.size() == 0) begin
            flag_error($sformatf("report %0d arrived with nothing pending", reports_seen));
            return;
         end
         want = pending_reports.pop_front();
         compare("far_x", want.far_x, got.far_x);
         compare("far_y", want.far_y, got.far_y);
         compare("far_z", want.far_z, got.far_z);
         compare("far_index", {1'b0, want.far_index}, {1'b0, got.far_index});
         compare("far_dist_sq", {1'b0, want.far_dist_sq}, {1'b0, got.far_dist_sq});
         compare("found", {1'b0, want.found}, {1'b0, got.found});
         compare("mean_x", want.mean_x, got.mean_x);
         compare("mean_y", want.mean_y, got.mean_y);
         compare("mean_z", want.mean_z, got.mean_z);
         compare("mean_valid", {1'b0, want.mean_valid}, {1'b0, got.mean_valid});
         compare("point_count", {1'b0, want.point_count}, {1'b0, got.point_count});
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // pos_x, pos_y, pos_z, point_index, zero pad
   logic                  req_tuser;    // first
   logic                  req_tlast;    // last
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // far_x, far_y, far_z, far_index, far_dist_sq, mean_x, mean_y, mean_z,
   // point_count, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;    // found
   logic                  rsp_tlast;    // mean_valid
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COORD_W-1:0]    csr_data;

   cloud_tracker_scoreboard sb = new();
   bit idle_en = 1'b1;
   int points_sent;
   int clouds_sent;
   int tip_settings;
   int quiet_cycles;

   farthest_point_and_centroid_tracker_unit #(
      .MAX_POINTS(MAX_POINTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic point_type make_point(int x, int y, int z, int idx, bit first, bit last);
      point_type p;
      p.x     = x[COORD_W-1:0];
      p.y     = y[COORD_W-1:0];
      p.z     = z[COORD_W-1:0];
      p.idx   = idx[INDEX_W-1:0];
      p.first = first;
      p.last  = last;
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] tip_c);
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return tip_c;
         3: return tip_c ^ COORD_W'($urandom_range(0, 3));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Mostly fresh points; now and then one on the tip or a repeat of the last one (a tie).
   function automatic point_type random_point(point_type prev);
      point_type p;
      int        mode;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         p.x = sb.tip[0];
         p.y = sb.tip[1];
         p.z = sb.tip[2];
      end else if (mode == 1) begin
         p = prev;
      end else begin
         p.x = pick_coord(sb.tip[0]);
         p.y = pick_coord(sb.tip[1]);
         p.z = pick_coord(sb.tip[2]);
      end
      p.idx   = INDEX_W'($urandom);
      p.first = 1'b0;
      p.last  = 1'b0;
      return p;
   endfunction

   task automatic send_point(point_type p);
      int gap;
      gap = idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 3*COORD_W - INDEX_W){1'b0}}, p.idx, p.z, p.y, p.x};
      req_tuser  <= p.first;
      req_tlast  <= p.last;
      do @(posedge clock); while (!req_tready);
      points_sent++;
   endtask

   // Drop valid in the step of the last transfer so nothing is sent twice.
   task automatic stop_points();
      req_tvalid <= 1'b0;
   endtask

   task automatic settle();
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tips(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty,
                             logic signed [COORD_W-1:0] tz);
      logic [CSR_IDX_W-1:0] regs [3] = '{REG_TIP_X, REG_TIP_Y, REG_TIP_Z};
      logic [COORD_W-1:0]   vals [3];
      vals = '{tx, ty, tz};
      for (int r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[r];
         csr_data  <= vals[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      tip_settings++;
   endtask

   task automatic send_cloud(int len);
      point_type p;
      p = make_point(0, 0, 0, 0, 0, 0);
      idle_en = ($urandom_range(0, 3) != 0);
      clouds_sent++;
      for (int i = 0; i < len; i++) begin
         p = random_point(p);
         // occasionally skip the start flag so the cloud carries on, or ask for a mean early
         p.first = (i == 0) && ($urandom_range(0, 7) != 0);
         p.last  = (i == len - 1) || ($urandom_range(0, 19) == 0);
         send_point(p);
      end
   endtask

   initial begin : receiver
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_en ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : monitor
      report_type got;
      bit         moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            sb.set_tip(csr_index, csr_data);
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            sb.note_point(make_point($signed(req_tdata[15:0]), $signed(req_tdata[31:16]),
                                     $signed(req_tdata[47:32]), int'(req_tdata[67:48]),
                                     req_tuser, req_tlast));
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.far_x       = rsp_tdata[15:0];
            got.far_y       = rsp_tdata[31:16];
            got.far_z       = rsp_tdata[47:32];
            got.far_index   = rsp_tdata[67:48];
            got.far_dist_sq = rsp_tdata[101:68];
            got.mean_x      = rsp_tdata[117:102];
            got.mean_y      = rsp_tdata[133:118];
            got.mean_z      = rsp_tdata[149:134];
            got.point_count = rsp_tdata[162:150];
            got.found       = rsp_tuser;
            got.mean_valid  = rsp_tlast;
            sb.check_report(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d reports pending",
                     QUIET_LIMIT, sb.pending_reports.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : main
      int n;
      int len;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_TIP_X;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // tip still at its reset value: a point on the tip, then mean rounding ties
      send_point(make_point(0, 0, 0, 5, 1, 1));
      send_point(make_point(1, -1, 2, 1, 1, 0));
      send_point(make_point(2, -2, 1, 2, 0, 1));
      stop_points();
      settle();

      // tip at a corner: largest distance, a tie, a point on the tip, continued clouds
      write_tips(-32768, 32767, -32768);
      send_point(make_point(32767, -32768, 32767, 'hFFFFF, 1, 0));
      send_point(make_point(32767, -32768, 32767, 0, 0, 0));
      send_point(make_point(-32768, 32767, -32768, 7, 0, 0));
      send_point(make_point(-32768, -32768, -32768, 3, 0, 1));
      send_point(make_point(-32768, -32768, -32768, 9, 0, 1));
      send_point(make_point(32767, 32767, 32767, 'h5A5A5, 1, 1));
      send_point(make_point(-32768, -32768, -32768, 'hA5A5A, 1, 0));
      send_point(make_point(-32768, -32768, -32768, 4, 0, 1));
      send_point(make_point(-32768, 32767, -32768, 8, 1, 0));
      send_point(make_point(-3, 5, -7, 6, 0, 0));
      send_point(make_point(-2, 4, -8, 12, 0, 1));
      stop_points();
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_tips(32767, 32767, 32767);
            1: write_tips(-32768, -32768, -32768);
            2: write_tips(0, 0, 0);
            default: write_tips(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
         endcase
         n = 0;
         while (n < 165) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            send_cloud(len);
            n += len;
         end
         stop_points();
         settle();
      end

      write_tips(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      send_cloud(8);
      stop_points();
      settle();

      $display("Sent %0d points in %0d clouds under %0d tip settings.",
               points_sent, clouds_sent, tip_settings);
      $display("Checked %0d reports, %0d carrying a mean; %0d mismatches.",
               sb.reports_seen, sb.means_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
